@@ hw/rtl/cbf_pkg.sv @@
// shared types, constants and reduction function of the counting bloom filter
package cbf_pkg;

    localparam int DIGEST_W      = 64;
    localparam int DIGEST_FIELDS = 4;
    localparam int HIDX_W        = 2;
    localparam int RED_BITS      = 8;
    localparam int RED_STEPS     = DIGEST_W / RED_BITS;
    localparam int STEP_W        = $clog2(RED_STEPS);
    localparam int CELLS_W       = 13;
    localparam int HCOUNT_W      = 3;
    localparam int EST_W         = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT   = 1'b1;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_COUNT = 1'b1;

    localparam logic [EST_W-1:0]    EST_MAX          = '1;
    localparam logic [CELLS_W-1:0]  CELLS_RESET      = 13'd4096;
    localparam logic [HCOUNT_W-1:0] HASH_COUNT_RESET = 3'd4;

    typedef struct packed {
        logic              clear;
        logic              start;
        logic              reduce;
        logic              rd_en;
        logic              update;
        logic              finish;
        logic [HIDX_W-1:0] hash;
    } cbf_cmd_t;

    typedef struct packed {
        logic              clear_last;
        logic              is_count;
        logic [HIDX_W-1:0] k_last;
        logic              out_busy;
    } cbf_status_t;

    // shifts RED_BITS digest bits into a remainder that stays below n
    function automatic logic [CELLS_W-1:0] mod_step(
        input logic [CELLS_W-1:0]  rem,
        input logic [RED_BITS-1:0] bits,
        input logic [CELLS_W-1:0]  n
    );
        logic [CELLS_W-1:0] r;
        logic [CELLS_W:0]   t;
        r = rem;
        for (int i = RED_BITS - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, n})
            begin
                t = t - {1'b0, n};
            end
            r = t[CELLS_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cbf_if.sv @@
// handshake channel interfaces for items and results
interface cbf_item_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [cbf_pkg::DIGEST_W-1:0]   digest_0;
    logic [cbf_pkg::DIGEST_W-1:0]   digest_1;
    logic [cbf_pkg::DIGEST_W-1:0]   digest_2;
    logic [cbf_pkg::DIGEST_W-1:0]   digest_3;

    modport source (output valid, mode, digest_0, digest_1, digest_2, digest_3,
                    input ready);
    modport sink   (input valid, mode, digest_0, digest_1, digest_2, digest_3,
                    output ready);
endinterface

interface cbf_result_if;
    logic                        valid;
    logic                        ready;
    logic [cbf_pkg::EST_W-1:0]   estimate;
    logic                        is_member;

    modport source (output valid, estimate, is_member, input ready);
    modport sink   (input valid, estimate, is_member, output ready);
endinterface

@@ hw/rtl/cbf_ram.sv @@
// generic single-write, single-read ram with registered read data
module cbf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/cbf_ctrl.sv @@
// controller: clearing pass, reduction steps and per-hash read-modify-write
module cbf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  cbf_pkg::cbf_status_t  status,
    output cbf_pkg::cbf_cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_REDUCE = 6'b000100,
        ST_READ   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } cbf_state_t;

    cbf_state_t                     state_reg, state_next;
    logic [cbf_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [cbf_pkg::HIDX_W-1:0]     hash_reg, hash_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        hash_next  = hash_reg;
        cmd        = '0;
        cmd.hash   = hash_reg;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    hash_next  = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == cbf_pkg::STEP_W'(cbf_pkg::RED_STEPS - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (hash_reg == status.k_last)
                begin
                    state_next = status.is_count ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    hash_next  = hash_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                // result waits here until the output slot frees up
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            hash_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            hash_reg  <= hash_next;
        end
    end

endmodule

@@ hw/rtl/cbf_datapath.sv @@
// datapath: digest reducers, counter store, minimum tracker and result register
module cbf_datapath #(
    parameter int CELLS        = 4096,
    parameter int COUNTER_BITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cbf_pkg::cbf_cmd_t               cmd,
    output cbf_pkg::cbf_status_t            status,
    input  logic [cbf_pkg::CELLS_W-1:0]     n_eff,
    input  logic [cbf_pkg::HCOUNT_W-1:0]    k_eff,
    input  logic                            mode,
    input  logic [cbf_pkg::DIGEST_W-1:0]    digest_0,
    input  logic [cbf_pkg::DIGEST_W-1:0]    digest_1,
    input  logic [cbf_pkg::DIGEST_W-1:0]    digest_2,
    input  logic [cbf_pkg::DIGEST_W-1:0]    digest_3,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [cbf_pkg::EST_W-1:0]       estimate,
    output logic                            is_member
);

    localparam int AW = $clog2(CELLS);
    localparam int XW = COUNTER_BITS + cbf_pkg::EST_W;
    localparam int DW = cbf_pkg::DIGEST_W;

    logic [DW-1:0]               dig_reg [cbf_pkg::DIGEST_FIELDS];
    logic [cbf_pkg::CELLS_W-1:0] rem_reg [cbf_pkg::DIGEST_FIELDS];
    logic [cbf_pkg::CELLS_W-1:0] n_reg;
    logic [cbf_pkg::HIDX_W-1:0]  k_last_reg;
    logic                        mode_reg;
    logic [AW-1:0]               idx_reg;
    logic [COUNTER_BITS-1:0]     min_reg;
    logic [AW-1:0]               clr_addr_reg;
    logic                        out_valid_reg;
    logic [cbf_pkg::EST_W-1:0]   est_reg;
    logic                        member_reg;

    logic [DW-1:0]               dig_in [cbf_pkg::DIGEST_FIELDS];
    logic [AW-1:0]               rd_idx;
    logic [COUNTER_BITS-1:0]     rd_data;
    logic [COUNTER_BITS-1:0]     inc_val;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [COUNTER_BITS-1:0]     ram_wdata;
    logic [XW-1:0]               min_x;

    assign dig_in[0] = digest_0;
    assign dig_in[1] = digest_1;
    assign dig_in[2] = digest_2;
    assign dig_in[3] = digest_3;

    // remainder is below n, which never exceeds the store depth
    assign rd_idx  = AW'(rem_reg[cmd.hash]);
    assign inc_val = (rd_data == '1) ? rd_data : rd_data + 1'b1;

    assign ram_we    = cmd.clear || (cmd.update && (mode_reg == cbf_pkg::MODE_ADD));
    assign ram_waddr = cmd.clear ? clr_addr_reg : idx_reg;
    assign ram_wdata = cmd.clear ? '0 : inc_val;

    cbf_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_idx),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cbf_pkg::DIGEST_FIELDS; i++)
        begin
            if (cmd.start)
            begin
                dig_reg[i] <= dig_in[i];
                rem_reg[i] <= '0;
            end
            else if (cmd.reduce)
            begin
                rem_reg[i] <= cbf_pkg::mod_step(rem_reg[i],
                                                dig_reg[i][DW-1 -: cbf_pkg::RED_BITS],
                                                n_reg);
                dig_reg[i] <= dig_reg[i] << cbf_pkg::RED_BITS;
            end
        end
        if (cmd.start)
        begin
            n_reg      <= n_eff;
            k_last_reg <= cbf_pkg::HIDX_W'(k_eff - 1'b1);
            mode_reg   <= mode;
            min_reg    <= '1;
        end
        if (cmd.rd_en)
        begin
            idx_reg <= rd_idx;
        end
        if (cmd.update && (rd_data < min_reg))
        begin
            min_reg <= rd_data;
        end
        if (cmd.finish)
        begin
            est_reg    <= (min_x > XW'(cbf_pkg::EST_MAX)) ? cbf_pkg::EST_MAX
                                                          : min_x[cbf_pkg::EST_W-1:0];
            member_reg <= (min_reg != '0);
        end
    end

    assign min_x = XW'(min_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = (clr_addr_reg == AW'(CELLS - 1));
    assign status.is_count   = (mode_reg == cbf_pkg::MODE_COUNT);
    assign status.k_last     = k_last_reg;
    assign status.out_busy   = out_valid_reg && !result_ready;

    assign result_valid = out_valid_reg;
    assign estimate     = est_reg;
    assign is_member    = member_reg;

endmodule

@@ hw/rtl/counting_bloom_filter.sv @@
// counting bloom filter top level: config registers, controller and datapath
// an item is taken in the idle state, then reduction steps of 8 bits a cycle reduce all digests,
// then each hash in use does the counter read-modify-write on the store, a read state then an update state
// add items return to idle after the last hash; count items then wait in a done state until the
// output slot is free, and the result is registered from there
// after reset a clearing pass zeroes every store cell before items are taken
module counting_bloom_filter #(
    parameter int CELLS        = 4096,
    parameter int COUNTER_BITS = 4,
    parameter int MAX_HASHES   = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cbf_item_if.sink                          item,
    cbf_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam logic [cbf_pkg::CELLS_W-1:0] CELLS_CAP =
        (CELLS < (1 << cbf_pkg::CELLS_W)) ? cbf_pkg::CELLS_W'(CELLS)
                                          : '1;
    localparam logic [cbf_pkg::HCOUNT_W-1:0] HASH_LIM =
        (MAX_HASHES < cbf_pkg::DIGEST_FIELDS) ? cbf_pkg::HCOUNT_W'(MAX_HASHES)
                                              : cbf_pkg::HCOUNT_W'(cbf_pkg::DIGEST_FIELDS);

    logic [cbf_pkg::CELLS_W-1:0]  cells_reg, cells_next;
    logic [cbf_pkg::HCOUNT_W-1:0] hcount_reg, hcount_next;
    logic [cbf_pkg::CELLS_W-1:0]  n_eff;
    logic [cbf_pkg::HCOUNT_W-1:0] k_eff;
    cbf_pkg::cbf_cmd_t            cmd;
    cbf_pkg::cbf_status_t         status;

    always_comb
    begin
        cells_next  = cells_reg;
        hcount_next = hcount_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cbf_pkg::CFG_CELLS_IN_USE: cells_next  = cfg_wdata[cbf_pkg::CELLS_W-1:0];
                cbf_pkg::CFG_HASH_COUNT:   hcount_next = cfg_wdata[cbf_pkg::HCOUNT_W-1:0];
                default:                   cells_next  = cells_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg  <= cbf_pkg::CELLS_RESET;
            hcount_reg <= cbf_pkg::HASH_COUNT_RESET;
        end
        else
        begin
            cells_reg  <= cells_next;
            hcount_reg <= hcount_next;
        end
    end

    // zero means one, anything past the limit means the limit
    always_comb
    begin
        priority if (cells_reg == '0)
            n_eff = cbf_pkg::CELLS_W'(1);
        else if (cells_reg > CELLS_CAP)
            n_eff = CELLS_CAP;
        else
            n_eff = cells_reg;
        priority if (hcount_reg == '0)
            k_eff = cbf_pkg::HCOUNT_W'(1);
        else if (hcount_reg > HASH_LIM)
            k_eff = HASH_LIM;
        else
            k_eff = hcount_reg;
    end

    cbf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    cbf_datapath #(
        .CELLS        (CELLS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .n_eff        (n_eff),
        .k_eff        (k_eff),
        .mode         (item.mode),
        .digest_0     (item.digest_0),
        .digest_1     (item.digest_1),
        .digest_2     (item.digest_2),
        .digest_3     (item.digest_3),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .estimate     (result.estimate),
        .is_member    (result.is_member)
    );

endmodule
